@@ hw/rtl/mcos_pkg.sv @@
`default_nettype none
package mcos_pkg;

   localparam int MAX_LEN = 64;
   localparam int GROUP   = 8;
   localparam int NGROUP  = (MAX_LEN + GROUP - 1) / GROUP;
   localparam int NLANE   = NGROUP * GROUP;

   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = $clog2(NLANE);
   localparam int CNT_W   = $clog2(2 * MAX_LEN + 1);
   localparam int GRP_W   = $clog2(3 * GROUP + 1);
   localparam int SUM_W   = $clog2(3 * MAX_LEN + 1);
   localparam int OUT_W   = 8;
   localparam int SAT_W   = (SUM_W > OUT_W) ? SUM_W : OUT_W;

   localparam int SCORE_SAT = 255;
   localparam int MAX_SCORE = (3 * MAX_LEN > SCORE_SAT) ? SCORE_SAT : 3 * MAX_LEN;

   localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [1:0] OP_COMPUTE       = 2'd2;
   localparam logic [1:0] OP_UNUSED        = 2'd3;

   localparam logic [2:0] BASE_A    = 3'd0;
   localparam logic [2:0] BASE_C    = 3'd1;
   localparam logic [2:0] BASE_G    = 3'd2;
   localparam logic [2:0] BASE_U    = 3'd3;
   localparam logic [2:0] BASE_NONE = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic append_first;
      logic append_second;
      logic init;
      logic shift;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] shift_total;
      logic             pipe_busy;
      logic             rsp_full;
   } status_type;

   function automatic logic [1:0] pair_score(input logic [2:0] x, input logic [2:0] y);
      logic [1:0] s;
      s = 2'd0;
      if ((x == BASE_G && y == BASE_C) || (x == BASE_C && y == BASE_G)) begin
         s = 2'd3;
      end else if ((x == BASE_A && y == BASE_U) || (x == BASE_U && y == BASE_A)) begin
         s = 2'd2;
      end else if ((x == BASE_G && y == BASE_U) || (x == BASE_U && y == BASE_G)) begin
         s = 2'd1;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/max_complementarity_over_shifts_core.sv @@
`default_nettype none
// Sliding base-pair score maximum of two RNA strands. Requests with opcode 0 or 1 append one
// base to the first or second strand; bases past MAX_LEN are dropped and flagged. A compute
// request (opcode 2) slides the second strand past the first one offset per cycle, scores all
// MAX_LEN lanes in parallel and sums them in a registered adder tree; the window shift feeds a
// four-stage score/sum/maximum pipeline, whose result is registered as the response. The
// strands and overflow flag are cleared once the response is produced. Appends are taken while
// a response waits; a new compute request waits until the previous response is taken.
module max_complementarity_over_shifts_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [2:0]                  req_base,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [mcos_pkg::OUT_W-1:0]       rsp_max_score,
   output logic                             rsp_overflow
);

   mcos_pkg::cmd_type    cmd;
   mcos_pkg::status_type status;

   mcos_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   mcos_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_base      (req_base),
      .status        (status),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_max_score (rsp_max_score),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
`default_nettype wire

@@ hw/rtl/mcos_datapath.sv @@
`default_nettype none
module mcos_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mcos_pkg::cmd_type           cmd,
   input  wire logic [2:0]                  req_base,
   output mcos_pkg::status_type             status,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic [mcos_pkg::OUT_W-1:0]       rsp_max_score,
   output logic                             rsp_overflow
);

   logic [2:0]                    first_ff  [mcos_pkg::NLANE];
   logic [2:0]                    first_in  [mcos_pkg::NLANE];
   logic [2:0]                    second_ff [mcos_pkg::MAX_LEN];
   logic [2:0]                    second_in [mcos_pkg::MAX_LEN];
   logic [2:0]                    win_ff    [mcos_pkg::NLANE];
   logic [2:0]                    win_in    [mcos_pkg::NLANE];
   logic [1:0]                    score_ff  [mcos_pkg::NLANE];
   logic [1:0]                    score_in  [mcos_pkg::NLANE];
   logic [mcos_pkg::GRP_W-1:0]    grp_ff    [mcos_pkg::NGROUP];
   logic [mcos_pkg::GRP_W-1:0]    grp_in    [mcos_pkg::NGROUP];

   logic [mcos_pkg::LEN_W-1:0]    first_len_ff, first_len_in;
   logic [mcos_pkg::LEN_W-1:0]    second_len_ff, second_len_in;
   logic                          overflow_ff, overflow_in;
   logic [mcos_pkg::CNT_W-1:0]    fed_ff, fed_in;
   logic [mcos_pkg::SUM_W-1:0]    total_ff, total_in;
   logic [mcos_pkg::SUM_W-1:0]    best_ff, best_in;
   logic                          win_vld_ff, win_vld_in;
   logic                          score_vld_ff, score_vld_in;
   logic                          grp_vld_ff, grp_vld_in;
   logic                          total_vld_ff, total_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mcos_pkg::OUT_W-1:0]    rsp_score_ff, rsp_score_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic                          first_full;
   logic                          second_full;

   assign first_full  = (first_len_ff == mcos_pkg::LEN_W'(mcos_pkg::MAX_LEN));
   assign second_full = (second_len_ff == mcos_pkg::LEN_W'(mcos_pkg::MAX_LEN));

   // strand stores and lengths
   always_comb begin
      first_in      = first_ff;
      second_in     = second_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      if (cmd.append_first) begin
         if (first_full) begin
            overflow_in = 1'b1;
         end else begin
            first_in[mcos_pkg::IDX_W'(first_len_ff)] = req_base;
            first_len_in = first_len_ff + 1'b1;
         end
      end
      if (cmd.append_second) begin
         if (second_full) begin
            overflow_in = 1'b1;
         end else begin
            second_in[0] = req_base;
            for (int k = 1; k < mcos_pkg::MAX_LEN; k++) begin
               second_in[k] = second_ff[k-1];
            end
            second_len_in = second_len_ff + 1'b1;
         end
      end
      if (cmd.shift) begin
         for (int k = 0; k < mcos_pkg::MAX_LEN - 1; k++) begin
            second_in[k] = second_ff[k+1];
         end
         second_in[mcos_pkg::MAX_LEN-1] = mcos_pkg::BASE_NONE;
      end
      if (cmd.finish) begin
         first_len_in  = '0;
         second_len_in = '0;
         overflow_in   = 1'b0;
      end
   end

   // sliding window of the second strand against the first
   always_comb begin
      win_in = win_ff;
      fed_in = fed_ff;
      if (cmd.init) begin
         for (int k = 0; k < mcos_pkg::NLANE; k++) begin
            win_in[k] = mcos_pkg::BASE_NONE;
         end
         fed_in = '0;
      end else if (cmd.shift) begin
         win_in[0] = (fed_ff < mcos_pkg::CNT_W'(second_len_ff)) ? second_ff[0]
                                                               : mcos_pkg::BASE_NONE;
         for (int k = 1; k < mcos_pkg::NLANE; k++) begin
            win_in[k] = win_ff[k-1];
         end
         fed_in = fed_ff + 1'b1;
      end
   end

   // score lanes and adder tree
   always_comb begin
      for (int i = 0; i < mcos_pkg::NLANE; i++) begin
         score_in[i] = (i < int'(first_len_ff)) ? mcos_pkg::pair_score(first_ff[i], win_ff[i])
                                               : 2'd0;
      end
      for (int g = 0; g < mcos_pkg::NGROUP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < mcos_pkg::GROUP; k++) begin
            grp_in[g] = grp_in[g] + mcos_pkg::GRP_W'(score_ff[g * mcos_pkg::GROUP + k]);
         end
      end
      total_in = '0;
      for (int g = 0; g < mcos_pkg::NGROUP; g++) begin
         total_in = total_in + mcos_pkg::SUM_W'(grp_ff[g]);
      end
   end

   always_comb begin
      win_vld_in   = cmd.shift;
      score_vld_in = win_vld_ff;
      grp_vld_in   = score_vld_ff;
      total_vld_in = grp_vld_ff;
      best_in      = best_ff;
      if (cmd.init) begin
         best_in = '0;
      end else if (total_vld_ff && (total_ff > best_ff)) begin
         best_in = total_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = overflow_ff;
         if (mcos_pkg::SAT_W'(best_ff) > mcos_pkg::SAT_W'(mcos_pkg::SCORE_SAT)) begin
            rsp_score_in = mcos_pkg::OUT_W'(mcos_pkg::SCORE_SAT);
         end else begin
            rsp_score_in = mcos_pkg::OUT_W'(best_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      second_ff    <= second_in;
      win_ff       <= win_in;
      score_ff     <= score_in;
      grp_ff       <= grp_in;
      fed_ff       <= fed_in;
      total_ff     <= total_in;
      best_ff      <= best_in;
      rsp_score_ff <= rsp_score_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
         win_vld_ff    <= 1'b0;
         score_vld_ff  <= 1'b0;
         grp_vld_ff    <= 1'b0;
         total_vld_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
         win_vld_ff    <= win_vld_in;
         score_vld_ff  <= score_vld_in;
         grp_vld_ff    <= grp_vld_in;
         total_vld_ff  <= total_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign status.shift_total = mcos_pkg::CNT_W'(first_len_ff) + mcos_pkg::CNT_W'(second_len_ff);
   assign status.pipe_busy   = win_vld_ff | score_vld_ff | grp_vld_ff | total_vld_ff;
   assign status.rsp_full    = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_score = rsp_score_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule
`default_nettype wire

@@ hw/rtl/mcos_controller.sv @@
`default_nettype none
module mcos_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire mcos_pkg::status_type  status,
   output mcos_pkg::cmd_type          cmd
);

   mcos_pkg::state_type          state_ff, state_in;
   logic [mcos_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         accept;
   logic                         last_shift;

   assign last_shift = (cnt_ff == status.shift_total - 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcos_pkg::ST_IDLE: begin
            if (accept && req_opcode == mcos_pkg::OP_COMPUTE) begin
               state_in = mcos_pkg::ST_INIT;
            end
         end
         mcos_pkg::ST_INIT: begin
            state_in = (status.shift_total == '0) ? mcos_pkg::ST_DRAIN : mcos_pkg::ST_RUN;
         end
         mcos_pkg::ST_RUN: begin
            if (last_shift) begin
               state_in = mcos_pkg::ST_DRAIN;
            end
         end
         mcos_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = mcos_pkg::ST_FINISH;
            end
         end
         mcos_pkg::ST_FINISH: begin
            state_in = mcos_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcos_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cnt_in    = cnt_ff;
      case (state_ff)
         mcos_pkg::ST_IDLE: begin
            req_ready = !(req_opcode == mcos_pkg::OP_COMPUTE && status.rsp_full);
         end
         mcos_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            cnt_in   = '0;
         end
         mcos_pkg::ST_RUN: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
         end
         mcos_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.append_first  = accept && req_opcode == mcos_pkg::OP_APPEND_FIRST;
      cmd.append_second = accept && req_opcode == mcos_pkg::OP_APPEND_SECOND;
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcos_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mcos_checker.sv @@
`default_nettype none
module mcos_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [1:0]                  req_opcode,
   input wire logic [2:0]                  req_base,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [mcos_pkg::OUT_W-1:0]  rsp_max_score,
   input wire logic                        rsp_overflow
);

   logic compute_taken;

   assign compute_taken = req_valid && req_ready && req_opcode == mcos_pkg::OP_COMPUTE;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_score) && $stable(rsp_overflow))
      else $error("response changed while stalled");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_score <= mcos_pkg::OUT_W'(mcos_pkg::MAX_SCORE))
      else $error("score out of range");

   a_compute_needs_room: assert property (@(posedge clock) disable iff (reset)
      compute_taken |-> !rsp_valid)
      else $error("compute request taken while response pending");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      compute_taken |=> !req_ready && !rsp_valid)
      else $error("block not busy after compute request");

   a_base_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_base) || req_opcode == mcos_pkg::OP_COMPUTE
      || req_opcode == mcos_pkg::OP_UNUSED)
      else $error("unknown base on append");

endmodule

bind max_complementarity_over_shifts_core mcos_checker u_mcos_checker (.*);
`default_nettype wire

@@ tb/max_complementarity_over_shifts_checker.sv @@
`timescale 1ns / 1ps
module max_complementarity_over_shifts_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [2:0]                   req_base,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [mcos_pkg::OUT_W-1:0]   rsp_max_score,
   input  logic                         rsp_overflow,
   output int                           fail_count,
   output int                           pending_count
);
   import mcos_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] max_score;
      logic             overflow;
   } alignment_result_type;

   logic [2:0]           first_bases [MAX_LEN];
   logic [2:0]           second_bases [MAX_LEN];
   int                   first_count;
   int                   second_count;
   logic                 dropped_base;
   alignment_result_type expected_alignments [$];

   function automatic int base_pair_value(input logic [2:0] x, input logic [2:0] y);
      if ((x == BASE_G && y == BASE_C) || (x == BASE_C && y == BASE_G)) begin
         return 3;
      end
      if ((x == BASE_A && y == BASE_U) || (x == BASE_U && y == BASE_A)) begin
         return 2;
      end
      if ((x == BASE_G && y == BASE_U) || (x == BASE_U && y == BASE_G)) begin
         return 1;
      end
      return 0;
   endfunction

   function automatic logic [OUT_W-1:0] best_alignment_score();
      int best;
      int sum;
      int j;
      best = 0;
      if (first_count == 0 || second_count == 0) begin
         return '0;
      end
      for (int s = 0; s <= first_count + second_count - 2; s++) begin
         sum = 0;
         for (int i = 0; i < first_count; i++) begin
            j = i + second_count - 1 - s;
            if (j >= 0 && j < second_count) begin
               sum += base_pair_value(first_bases[i], second_bases[j]);
            end
         end
         if (sum > best) begin
            best = sum;
         end
      end
      if (best > SCORE_SAT) begin
         best = SCORE_SAT;
      end
      return best[OUT_W-1:0];
   endfunction

   always @(posedge clock) begin
      alignment_result_type want;
      if (reset) begin
         first_count  = 0;
         second_count = 0;
         dropped_base = 1'b0;
         fail_count   = 0;
         expected_alignments.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_alignments.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual max_score %0d overflow %0d",
                        $time, rsp_max_score, rsp_overflow);
               fail_count++;
            end else begin
               want = expected_alignments.pop_front();
               if (rsp_max_score !== want.max_score) begin
                  $display("%0t: max_score mismatch: expected %0d, actual %0d",
                           $time, want.max_score, rsp_max_score);
                  fail_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch: expected %0d, actual %0d",
                           $time, want.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_opcode)
               OP_APPEND_FIRST: begin
                  if (first_count < MAX_LEN) begin
                     first_bases[first_count] = req_base;
                     first_count++;
                  end else begin
                     dropped_base = 1'b1;
                  end
               end
               OP_APPEND_SECOND: begin
                  if (second_count < MAX_LEN) begin
                     second_bases[second_count] = req_base;
                     second_count++;
                  end else begin
                     dropped_base = 1'b1;
                  end
               end
               OP_COMPUTE: begin
                  want.max_score = best_alignment_score();
                  want.overflow  = dropped_base;
                  expected_alignments.push_back(want);
                  first_count  = 0;
                  second_count = 0;
                  dropped_base = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = expected_alignments.size();
   end

endmodule

@@ tb/max_complementarity_over_shifts_core_test.sv @@
`timescale 1ns / 1ps
module max_complementarity_over_shifts_core_test;
   import mcos_pkg::*;

   localparam logic [1:0] OP_RESERVED   = 2'd3;
   localparam logic [2:0] BASE_CODE_TOP = 3'd7;
   localparam int         REQUEST_GOAL  = 1700;
   localparam int         DRAIN_CYCLES  = 300;
   localparam int         CYCLE_LIMIT   = 600000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_opcode;
   logic [2:0]           req_base;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OUT_W-1:0]     rsp_max_score;
   logic                 rsp_overflow;
   int                   fail_count;
   int                   pending_count;
   int                   cycle_count;
   int                   requests_sent;
   int                   req_calm_left;
   int                   rsp_calm_left;

   max_complementarity_over_shifts_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_score (rsp_max_score),
      .rsp_overflow  (rsp_overflow)
   );

   max_complementarity_over_shifts_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_score (rsp_max_score),
      .rsp_overflow  (rsp_overflow),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Idle count with occasional stretches of back-to-back traffic
   function automatic int draw_idle(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic send_request(input logic [1:0] opcode, input logic [2:0] base);
      int idle;
      idle = draw_idle(req_calm_left);
      if (idle > 0) begin
         req_valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_opcode = opcode;
      req_base   = base;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (opcode != OP_RESERVED) begin
         requests_sent++;
      end
   endtask

   function automatic logic [2:0] draw_base();
      if ($urandom_range(0, 9) < 8) begin
         return 3'($urandom_range(BASE_A, BASE_U));
      end
      return 3'($urandom_range(BASE_NONE, BASE_CODE_TOP));
   endfunction

   task automatic send_strand_pair();
      logic [2:0] motif [MAX_LEN + 8];
      logic [2:0] partner;
      int         kind;
      int         first_left;
      int         second_left;
      int         idx;
      logic       use_first;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         first_left  = MAX_LEN;
         second_left = MAX_LEN;
      end else if (kind == 1) begin
         first_left  = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
         second_left = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      end else begin
         first_left  = $urandom_range(0, 12);
         second_left = (kind < 6) ? first_left : $urandom_range(0, 12);
      end
      for (int k = 0; k < MAX_LEN + 8; k++) begin
         motif[k] = (kind == 0) ? BASE_G : draw_base();
      end
      idx = 0;
      while (first_left > 0 || second_left > 0) begin
         if ($urandom_range(0, 29) == 0) begin
            send_request(OP_RESERVED, draw_base());
         end
         use_first = first_left > 0 && (second_left == 0 || $urandom_range(0, 1) == 1);
         // complementary sets load the first strand whole, then its pairing partner
         if (kind < 6) begin
            use_first = first_left > 0;
         end
         if (use_first) begin
            send_request(OP_APPEND_FIRST, motif[idx]);
            idx++;
            first_left--;
         end else if (kind < 6) begin
            case (motif[idx - second_left])
               BASE_G:  partner = ($urandom_range(0, 3) == 0) ? BASE_U : BASE_C;
               BASE_C:  partner = BASE_G;
               BASE_A:  partner = BASE_U;
               BASE_U:  partner = ($urandom_range(0, 3) == 0) ? BASE_G : BASE_A;
               default: partner = draw_base();
            endcase
            send_request(OP_APPEND_SECOND, partner);
            second_left--;
         end else begin
            send_request(OP_APPEND_SECOND, draw_base());
            second_left--;
         end
      end
      send_request(OP_COMPUTE, 3'($urandom_range(0, 7)));
   endtask

   initial begin
      rsp_ready     = 1'b0;
      rsp_calm_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int idle;
         idle = draw_idle(rsp_calm_left);
         if (idle > 0) begin
            rsp_ready = 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_APPEND_FIRST;
      req_base      = BASE_A;
      requests_sent = 0;
      req_calm_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(OP_COMPUTE, BASE_A);
      send_request(OP_APPEND_FIRST, BASE_G);
      send_request(OP_COMPUTE, BASE_A);
      send_request(OP_APPEND_SECOND, BASE_C);
      send_request(OP_COMPUTE, BASE_CODE_TOP);
      send_request(OP_APPEND_FIRST, BASE_G);
      send_request(OP_APPEND_FIRST, BASE_A);
      send_request(OP_APPEND_FIRST, BASE_U);
      send_request(OP_APPEND_FIRST, BASE_CODE_TOP);
      send_request(OP_APPEND_SECOND, BASE_C);
      send_request(OP_APPEND_SECOND, BASE_U);
      send_request(OP_APPEND_SECOND, BASE_A);
      send_request(OP_APPEND_SECOND, BASE_NONE);
      send_request(OP_RESERVED, BASE_CODE_TOP);
      send_request(OP_COMPUTE, BASE_A);
      send_request(OP_APPEND_FIRST, BASE_NONE);
      send_request(OP_APPEND_SECOND, BASE_NONE);
      send_request(OP_RESERVED, BASE_A);
      send_request(OP_COMPUTE, BASE_A);
      send_request(OP_APPEND_FIRST, BASE_U);
      send_request(OP_APPEND_SECOND, BASE_G);
      send_request(OP_COMPUTE, BASE_A);

      while (requests_sent < REQUEST_GOAL) begin
         send_strand_pair();
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mcos_pkg.sv
hw/rtl/mcos_datapath.sv
hw/rtl/mcos_controller.sv
hw/rtl/max_complementarity_over_shifts_core.sv
hw/rtl/mcos_checker.sv
tb/max_complementarity_over_shifts_checker.sv
tb/max_complementarity_over_shifts_core_test.sv
